FILE: hw/rtl/cti_pkg.sv
// Shared types and constants for the calibration table interpolator.
package cti_pkg;

  // Opcodes carried on the input word.
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Command kinds after the front end has classified a word.
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  // Field widths.
  localparam int SAMPLE_W = 10;
  localparam int PULSE_W  = 16;
  localparam int INDEX_W  = 3;
  localparam int ENTRY_W  = SAMPLE_W + PULSE_W;

  // Command queue geometry.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Serial divider: magnitude of the numerator fits in 27 bits.
  localparam int PROD_W    = 28;
  localparam int DIV_STEPS = 27;
  localparam int DIV_CNT_W = 5;

  // One classified command.
  typedef struct packed {
    logic [1:0]          kind;
    logic [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]  idx;
    logic [PULSE_W-1:0]  pwm;
  } cmd_t;

endpackage

FILE: hw/rtl/cti_ram.sv
// Generic single write port RAM with a registered read port.
module cti_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/cti_front.sv
// Front end: accepts input words and classifies them into commands.
module cti_front #(
  parameter int NUM_POINTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [cti_pkg::SAMPLE_W-1:0]  in_adc_sample,
  input  logic [cti_pkg::INDEX_W-1:0]   in_entry_index,
  input  logic [cti_pkg::PULSE_W-1:0]   in_entry_pwm,
  output logic                          cmd_valid,
  input  logic                          cmd_stall,
  output cti_pkg::cmd_t                 cmd
);

  logic          slot_v_r;
  cti_pkg::cmd_t slot_r;
  cti_pkg::cmd_t dec;
  logic          in_take;
  logic          idx_ok;

  // A store to an entry beyond the table is dropped as a no-op.
  assign idx_ok = (7'(in_entry_index) < 7'(NUM_POINTS));

  // Classify the incoming word.
  always_comb begin
    dec.sample = in_adc_sample;
    dec.idx    = in_entry_index;
    dec.pwm    = in_entry_pwm;
    case (in_opcode)
      cti_pkg::OP_LOOKUP: dec.kind = cti_pkg::KIND_LOOKUP;
      cti_pkg::OP_STORE:  dec.kind = idx_ok ? cti_pkg::KIND_STORE : cti_pkg::KIND_NOP;
      cti_pkg::OP_CLEAR:  dec.kind = cti_pkg::KIND_CLEAR;
      default:            dec.kind = cti_pkg::KIND_NOP;
    endcase
  end

  // The slot can take a word when it is empty or draining this cycle.
  assign in_stall = slot_v_r && cmd_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
    end else if (in_take) begin
      slot_v_r <= 1'b1;
    end else if (!cmd_stall) begin
      slot_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      slot_r <= dec;
    end
  end

  assign cmd_valid = slot_v_r;
  assign cmd       = slot_r;

endmodule

FILE: hw/rtl/cti_queue.sv
// Short command queue between the front end and the back end.
module cti_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_stall,
  input  cti_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_stall,
  output cti_pkg::cmd_t pop_cmd
);

  cti_pkg::cmd_t                entries_r [cti_pkg::QDEPTH];
  logic [cti_pkg::QPTR_W-1:0]   wptr_r;
  logic [cti_pkg::QPTR_W-1:0]   rptr_r;
  logic [cti_pkg::QCNT_W-1:0]   count_r;
  logic                         push;
  logic                         pop;

  assign push_stall = (count_r == cti_pkg::QCNT_W'(cti_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_cmd    = entries_r[rptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/cti_back.sv
// Back end: table storage, lookup scan, serial interpolation and result register.
module cti_back #(
  parameter int NUM_POINTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  cti_pkg::cmd_t                 cmd,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [cti_pkg::PULSE_W-1:0]   out_nearest_pwm,
  output logic [cti_pkg::PULSE_W-1:0]   out_interpolated_pwm
);

  localparam int IW = $clog2(NUM_POINTS);
  localparam int SW = cti_pkg::SAMPLE_W;
  localparam int PW = cti_pkg::PULSE_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN     = 4'd1;
  localparam logic [3:0] ST_SCAN_END = 4'd2;
  localparam logic [3:0] ST_RESOLVE  = 4'd3;
  localparam logic [3:0] ST_MUL      = 4'd4;
  localparam logic [3:0] ST_ADD      = 4'd5;
  localparam logic [3:0] ST_ABS      = 4'd6;
  localparam logic [3:0] ST_DIV      = 4'd7;
  localparam logic [3:0] ST_FIX      = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0]                 state_r;
  logic [3:0]                 state_nxt;
  logic [NUM_POINTS-1:0]      valid_r;
  logic [IW-1:0]              addr_r;
  logic                       eval_v_r;
  logic [IW-1:0]              eval_idx_r;
  logic [SW-1:0]              smp_r;
  logic                       have_le_r;
  logic                       have_ge_r;
  logic [SW-1:0]              dle_r;
  logic [SW-1:0]              dge_r;
  logic [SW-1:0]              le_s_r;
  logic [SW-1:0]              ge_s_r;
  logic [PW-1:0]              le_p_r;
  logic [PW-1:0]              ge_p_r;
  logic [SW-1:0]              span_r;
  logic signed [PW:0]         diff_r;
  logic signed [cti_pkg::PROD_W-1:0] prod_r;
  logic signed [cti_pkg::PROD_W-1:0] num_r;
  logic                       neg_r;
  logic [cti_pkg::DIV_STEPS-1:0] quo_r;
  logic [SW-1:0]              rem_r;
  logic [cti_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                       res_status_r;
  logic [PW-1:0]              res_near_r;
  logic [PW-1:0]              res_interp_r;
  logic                       out_valid_r;
  logic                       out_status_r;
  logic [PW-1:0]              out_near_r;
  logic [PW-1:0]              out_interp_r;

  logic                       out_free;
  logic                       cmd_take;
  logic [6:0]                 idx_ext;
  logic [IW-1:0]              waddr;
  logic                       ram_we;
  logic                       ram_re;
  logic [cti_pkg::ENTRY_W-1:0] ram_rdata;
  logic [SW-1:0]              rd_s;
  logic [PW-1:0]              rd_p;
  logic                       ev_ok;
  logic                       le_upd;
  logic                       ge_upd;
  logic [SW:0]                span_inc;
  logic [SW-1:0]              half;
  logic signed [cti_pkg::PROD_W-1:0] neg_num;
  logic [SW:0]                trial;
  logic                       trial_ge;
  logic [PW-1:0]              q16;
  logic [PW-1:0]              q_signed;

  assign out_free  = !out_valid_r || !out_stall;
  assign cmd_stall = !((state_r == ST_IDLE) && out_free);
  assign cmd_take  = cmd_valid && !cmd_stall;

  // Store address; the front end has already dropped out-of-range stores.
  assign idx_ext = 7'(cmd.idx);
  assign waddr   = idx_ext[IW-1:0];
  assign ram_we  = cmd_take && (cmd.kind == cti_pkg::KIND_STORE);
  assign ram_re  = (state_r == ST_SCAN);

  cti_ram #(
    .WIDTH (cti_pkg::ENTRY_W),
    .DEPTH (NUM_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({cmd.sample, cmd.pwm}),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign rd_s = ram_rdata[cti_pkg::ENTRY_W-1:PW];
  assign rd_p = ram_rdata[PW-1:0];

  // Scan compare: strict less-than keeps the earliest entry on equal distance.
  assign ev_ok  = eval_v_r && valid_r[eval_idx_r];
  assign le_upd = ev_ok && (rd_s <= smp_r) && (!have_le_r || ((smp_r - rd_s) < dle_r));
  assign ge_upd = ev_ok && (rd_s >= smp_r) && (!have_ge_r || ((rd_s - smp_r) < dge_r));

  // Rounding term and numerator magnitude.
  assign span_inc = {1'b0, span_r} + 1'b1;
  assign half     = span_inc[SW:1];
  assign neg_num  = -num_r;

  // One restoring division step per cycle.
  assign trial    = {rem_r, quo_r[cti_pkg::DIV_STEPS-1]};
  assign trial_ge = (trial >= {1'b0, span_r});

  // Apply the quotient sign and add the lower point.
  assign q16      = quo_r[PW-1:0];
  assign q_signed = neg_r ? (~q16 + 1'b1) : q16;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_take && (cmd.kind == cti_pkg::KIND_LOOKUP)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_r == IW'(NUM_POINTS - 1)) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_nxt = ST_RESOLVE;
      ST_RESOLVE: begin
        if (have_le_r && have_ge_r && (dle_r != '0)) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_ABS;
      ST_ABS: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == cti_pkg::DIV_CNT_W'(cti_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state: sequencer, valid marks, scan pipeline flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      eval_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      eval_v_r <= (state_r == ST_SCAN);
      if (cmd_take && (cmd.kind == cti_pkg::KIND_CLEAR)) begin
        valid_r <= '0;
      end else if (ram_we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  // Scan address and best-candidate tracking.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      smp_r     <= cmd.sample;
      addr_r    <= '0;
      have_le_r <= 1'b0;
      have_ge_r <= 1'b0;
    end else begin
      if (state_r == ST_SCAN) begin
        addr_r <= addr_r + 1'b1;
      end
      if (le_upd) begin
        have_le_r <= 1'b1;
        dle_r     <= smp_r - rd_s;
        le_s_r    <= rd_s;
        le_p_r    <= rd_p;
      end
      if (ge_upd) begin
        have_ge_r <= 1'b1;
        dge_r     <= rd_s - smp_r;
        ge_s_r    <= rd_s;
        ge_p_r    <= rd_p;
      end
    end
    eval_idx_r <= addr_r;
  end

  // Resolve the outcome, then multiply, round, divide and correct.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_RESOLVE: begin
        span_r <= ge_s_r - le_s_r;
        diff_r <= $signed({1'b0, ge_p_r}) - $signed({1'b0, le_p_r});
        if (!have_le_r && !have_ge_r) begin
          res_status_r <= 1'b1;
          res_near_r   <= '0;
          res_interp_r <= '0;
        end else if (!have_le_r || (have_ge_r && (dle_r == '0))) begin
          res_status_r <= 1'b0;
          res_near_r   <= ge_p_r;
          res_interp_r <= ge_p_r;
        end else if (!have_ge_r) begin
          res_status_r <= 1'b0;
          res_near_r   <= le_p_r;
          res_interp_r <= le_p_r;
        end else begin
          res_status_r <= 1'b0;
          res_near_r   <= (dle_r < dge_r) ? le_p_r : ge_p_r;
        end
      end
      ST_MUL: begin
        prod_r <= cti_pkg::PROD_W'(diff_r * $signed({1'b0, dle_r}));
      end
      ST_ADD: begin
        num_r <= prod_r + $signed({{(cti_pkg::PROD_W - SW){1'b0}}, half});
      end
      ST_ABS: begin
        neg_r <= num_r[cti_pkg::PROD_W-1];
        quo_r <= num_r[cti_pkg::PROD_W-1] ? neg_num[cti_pkg::DIV_STEPS-1:0]
                                          : num_r[cti_pkg::DIV_STEPS-1:0];
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= trial_ge ? SW'(trial - {1'b0, span_r}) : trial[SW-1:0];
        quo_r <= {quo_r[cti_pkg::DIV_STEPS-2:0], trial_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_FIX: begin
        res_interp_r <= le_p_r + q_signed;
      end
      default: begin
      end
    endcase
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd_take && (cmd.kind != cti_pkg::KIND_LOOKUP)) ||
                 ((state_r == ST_DONE) && out_free)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: result word.
  always_ff @(posedge clk) begin
    if (cmd_take && (cmd.kind != cti_pkg::KIND_LOOKUP)) begin
      out_status_r <= 1'b0;
      out_near_r   <= '0;
      out_interp_r <= '0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_status_r <= res_status_r;
      out_near_r   <= res_near_r;
      out_interp_r <= res_interp_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_nearest_pwm      = out_near_r;
  assign out_interpolated_pwm = out_interp_r;

endmodule

FILE: hw/rtl/calibration_table_interpolator.sv
// An interpolating lookup presents its result word after a scan with one RAM read per table
// entry, then a multiply, a rounding add, an absolute value, the serial divider and a fix-up.
// Lookups that need no interpolation skip the arithmetic; store, clear and no-op words load
// the output register as they are taken. The back end works on one command at a time, so a
// two-entry queue and the input slot keep accepting words while a lookup runs.
// Synchronous active-low reset empties the table, the queue and the output register.
module calibration_table_interpolator #(
  parameter int NUM_POINTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [9:0]  in_adc_sample,
  input  logic [2:0]  in_entry_index,
  input  logic [15:0] in_entry_pwm,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [15:0] out_nearest_pwm,
  output logic [15:0] out_interpolated_pwm
);

  logic          f_valid;
  logic          f_stall;
  cti_pkg::cmd_t f_cmd;
  logic          q_valid;
  logic          q_stall;
  cti_pkg::cmd_t q_cmd;

  // Accept and classify input words.
  cti_front #(
    .NUM_POINTS (NUM_POINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_adc_sample  (in_adc_sample),
    .in_entry_index (in_entry_index),
    .in_entry_pwm   (in_entry_pwm),
    .cmd_valid      (f_valid),
    .cmd_stall      (f_stall),
    .cmd            (f_cmd)
  );

  // Decouple the front end from the back end.
  cti_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_cmd    (q_cmd)
  );

  // Execute commands and hold the result word.
  cti_back #(
    .NUM_POINTS (NUM_POINTS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (q_valid),
    .cmd_stall            (q_stall),
    .cmd                  (q_cmd),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_nearest_pwm      (out_nearest_pwm),
    .out_interpolated_pwm (out_interpolated_pwm)
  );

endmodule

FILE: hw/rtl/cti_checker.sv
// Port-level checker for the calibration table interpolator, with its bind.
module cti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_opcode,
  input logic [9:0]  in_adc_sample,
  input logic [2:0]  in_entry_index,
  input logic [15:0] in_entry_pwm,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic [15:0] out_nearest_pwm,
  input logic [15:0] out_interpolated_pwm
);

  // A stalled input word stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_opcode) && $stable(in_adc_sample) &&
      $stable(in_entry_index) && $stable(in_entry_pwm))
    else $error("input word changed while stalled");

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_nearest_pwm) && $stable(out_interpolated_pwm))
    else $error("result word changed while stalled");

  // An empty-table error carries zero pulse widths.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_nearest_pwm == 16'd0) &&
      (out_interpolated_pwm == 16'd0))
    else $error("error word with nonzero pulse width");

  // Reset leaves no result word pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind calibration_table_interpolator cti_checker u_cti_checker (.*);

FILE: verif/tb_calibration_table_interpolator.sv
// Self-checking testbench for the calibration table interpolator.
`timescale 1ns / 1ps

module tb_calibration_table_interpolator;

  localparam int TABLE_DEPTH = 8;
  localparam int WORD_COUNT = 1300;
  localparam int REPORT_LIMIT = 10;
  localparam int SQUEEZE_CYCLES = 500;
  localparam logic [1:0] OP_IDLE = 2'd3;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [cti_pkg::SAMPLE_W-1:0] sample;
    logic [cti_pkg::INDEX_W-1:0]  entry;
    logic [cti_pkg::PULSE_W-1:0]  pwm;
  } cal_word_t;

  typedef struct packed {
    logic                        status;
    logic [cti_pkg::PULSE_W-1:0] nearest;
    logic [cti_pkg::PULSE_W-1:0] interp;
  } cal_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [9:0] in_adc_sample = '0;
  logic [2:0] in_entry_index = '0;
  logic [15:0] in_entry_pwm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic [15:0] out_nearest_pwm;
  logic [15:0] out_interpolated_pwm;

  // Words waiting to be sent and responses waiting to be seen.
  cal_word_t words_to_send[$];
  cal_result_t expected_responses[$];
  cal_word_t cur_word;

  // Shadow of the calibration table, updated as words are accepted.
  bit tbl_valid[TABLE_DEPTH];
  logic [cti_pkg::SAMPLE_W-1:0] tbl_sensor[TABLE_DEPTH];
  logic [cti_pkg::PULSE_W-1:0] tbl_pulse[TABLE_DEPTH];

  int words_accepted = 0;
  int error_count = 0;
  int send_gap = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  int hold_left = 0;
  int squeeze_stage = 0;

  calibration_table_interpolator #(
    .NUM_POINTS(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_adc_sample(in_adc_sample),
    .in_entry_index(in_entry_index),
    .in_entry_pwm(in_entry_pwm),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_nearest_pwm(out_nearest_pwm),
    .out_interpolated_pwm(out_interpolated_pwm)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Applies one word to the shadow table and returns the response it should produce.
  function automatic cal_result_t table_response(input cal_word_t w);
    cal_result_t r;
    bit have_lo, have_hi;
    int lo_i, hi_i, d_lo, d_hi, s, smp;
    longint pl, ph, span, num, val;
    r = '0;
    have_lo = 1'b0;
    have_hi = 1'b0;
    lo_i = 0;
    hi_i = 0;
    d_lo = 0;
    d_hi = 0;
    smp = w.sample;
    case (w.opcode)
      cti_pkg::OP_LOOKUP: begin
        // Nearest valid point on each side; strict compare keeps the lowest index on ties.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i]) begin
            s = tbl_sensor[i];
            if (s <= smp && (!have_lo || smp - s < d_lo)) begin
              have_lo = 1'b1;
              lo_i = i;
              d_lo = smp - s;
            end
            if (s >= smp && (!have_hi || s - smp < d_hi)) begin
              have_hi = 1'b1;
              hi_i = i;
              d_hi = s - smp;
            end
          end
        end
        if (!have_lo && !have_hi) begin
          r.status = 1'b1;
        end else if (!have_lo || (have_hi && lo_i == hi_i)) begin
          r.nearest = tbl_pulse[hi_i];
          r.interp = tbl_pulse[hi_i];
        end else if (!have_hi) begin
          r.nearest = tbl_pulse[lo_i];
          r.interp = tbl_pulse[lo_i];
        end else begin
          pl = tbl_pulse[lo_i];
          ph = tbl_pulse[hi_i];
          span = longint'(tbl_sensor[hi_i]) - longint'(tbl_sensor[lo_i]);
          r.nearest = (d_lo < d_hi) ? tbl_pulse[lo_i] : tbl_pulse[hi_i];
          if (span <= 0) begin
            val = ph;
          end else begin
            // Rounded slope term; SystemVerilog division truncates toward zero.
            num = (ph - pl) * longint'(d_lo) + ((span + 1) >>> 1);
            val = pl + num / span;
          end
          r.interp = 16'(val);
        end
      end
      cti_pkg::OP_STORE: begin
        tbl_valid[w.entry] = 1'b1;
        tbl_sensor[w.entry] = w.sample;
        tbl_pulse[w.entry] = w.pwm;
      end
      cti_pkg::OP_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Idle length for either side: mostly short, a few long, with calm stretches of none.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [cti_pkg::PULSE_W-1:0] pick_pulse();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_word(input logic [1:0] op, input int smp, input int idx, input int pwm);
    cal_word_t w;
    w.opcode = op;
    w.sample = cti_pkg::SAMPLE_W'(smp);
    w.entry = cti_pkg::INDEX_W'(idx);
    w.pwm = cti_pkg::PULSE_W'(pwm);
    words_to_send.push_back(w);
  endtask

  // Driver: holds each word until accepted, then waits a random gap before the next.
  always @(posedge clk) begin : driver_proc
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        expected_responses.push_back(table_response(cur_word));
        words_accepted <= words_accepted + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          cur_word = words_to_send.pop_front();
          in_opcode <= cur_word.opcode;
          in_adc_sample <= cur_word.sample;
          in_entry_index <= cur_word.entry;
          in_entry_pwm <= cur_word.pwm;
          in_valid <= 1'b1;
          send_gap = idle_len(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted response word and drives the receiver stall.
  always @(posedge clk) begin : monitor_proc
    cal_result_t got, want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_status, out_nearest_pwm, out_interpolated_pwm};
        if (expected_responses.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: unexpected response word status=%0d nearest=%0d interp=%0d",
                     $realtime, got.status, got.nearest, got.interp);
        end else begin
          want = expected_responses.pop_front();
          if (got.status !== want.status || got.nearest !== want.nearest ||
              got.interp !== want.interp) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("%0t: mismatch status %0d/%0d nearest %0d/%0d interp %0d/%0d (exp/act)",
                       $realtime, want.status, got.status, want.nearest, got.nearest,
                       want.interp, got.interp);
          end
        end
      end
      // Two long hold-offs let the input side back up while words keep coming.
      if (squeeze_stage < 2 && words_accepted >= (squeeze_stage + 1) * 400) begin
        hold_left = SQUEEZE_CYCLES;
        squeeze_stage++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        hold_left = idle_len(rx_calm);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_proc
    int seq_sensor[TABLE_DEPTH];
    int n_pts, n_look, smp, r, a, b;
    bit narrow;

    // Write every entry once with extreme values, then clear.
    add_word(cti_pkg::OP_STORE, 0, 0, 0);
    add_word(cti_pkg::OP_STORE, 1023, 1, 65535);
    add_word(cti_pkg::OP_STORE, 512, 2, 16'h5555);
    add_word(cti_pkg::OP_STORE, 341, 3, 16'haaaa);
    add_word(cti_pkg::OP_STORE, 1, 4, 1);
    add_word(cti_pkg::OP_STORE, 1022, 5, 65534);
    add_word(cti_pkg::OP_STORE, 700, 6, 300);
    add_word(cti_pkg::OP_STORE, 42, 7, 9000);
    add_word(cti_pkg::OP_CLEAR, 1023, 7, 65535);
    // Lookup on an empty table reports an error.
    add_word(cti_pkg::OP_LOOKUP, 1023, 7, 65535);
    add_word(OP_IDLE, 1023, 7, 65535);
    // Small table with a duplicate sensor value in entries one and three.
    add_word(cti_pkg::OP_STORE, 100, 0, 1000);
    add_word(cti_pkg::OP_STORE, 500, 1, 65535);
    add_word(cti_pkg::OP_STORE, 900, 2, 0);
    add_word(cti_pkg::OP_STORE, 500, 3, 7);
    // Below all, above all, exact hit, equal distance, nearer below, falling slope.
    add_word(cti_pkg::OP_LOOKUP, 0, 0, 0);
    add_word(cti_pkg::OP_LOOKUP, 1023, 0, 0);
    add_word(cti_pkg::OP_LOOKUP, 500, 0, 0);
    add_word(cti_pkg::OP_LOOKUP, 300, 0, 0);
    add_word(cti_pkg::OP_LOOKUP, 200, 0, 0);
    add_word(cti_pkg::OP_LOOKUP, 700, 0, 0);
    add_word(cti_pkg::OP_LOOKUP, 1000, 0, 0);
    add_word(cti_pkg::OP_LOOKUP, 100, 0, 0);

    // Random part: mostly table builds followed by lookups, the rest noise.
    while (words_to_send.size() < WORD_COUNT) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0)
          add_word(cti_pkg::OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 7),
                   $urandom);
        n_pts = $urandom_range(1, TABLE_DEPTH);
        narrow = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < n_pts; j++) begin
          seq_sensor[j] = narrow ? $urandom_range(0, 15) : $urandom_range(0, 1023);
          add_word(cti_pkg::OP_STORE, seq_sensor[j], $urandom_range(0, 7), pick_pulse());
        end
        n_look = $urandom_range(1, 10);
        for (int j = 0; j < n_look; j++) begin
          r = $urandom_range(0, 5);
          a = seq_sensor[$urandom_range(0, n_pts - 1)];
          b = seq_sensor[$urandom_range(0, n_pts - 1)];
          case (r)
            0, 1: smp = a;
            2: smp = a + $urandom_range(0, 2) - 1;
            3: smp = (a + b) / 2;
            default: smp = narrow ? $urandom_range(0, 20) : $urandom_range(0, 1023);
          endcase
          if (smp < 0) smp = 0;
          if (smp > 1023) smp = 1023;
          add_word(cti_pkg::OP_LOOKUP, smp, $urandom_range(0, 7), $urandom);
        end
      end else begin
        repeat ($urandom_range(1, 5))
          add_word(2'($urandom_range(0, 3)), $urandom_range(0, 1023), $urandom_range(0, 7),
                   pick_pulse());
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (words_to_send.size() != 0 || in_valid) @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin : watchdog_proc
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
